>>> rtl/eida_pkg.sv
// shared types and constants for the entity id allocator
// no dependencies

package eida_pkg;

  localparam int MAX_IDS_DEF = 1024;

  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_INACTIVE = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_C_WR,
    S_D_CHK,
    S_D_FIN,
    S_DONE
  } state_t;

endpackage

>>> rtl/eida_ram.sv
// generic single port ram with registered read
// no dependencies

module eida_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/eida_ctrl.sv
// command sequencer: reads, updates and writes back the sparse index and id store
// depends on eida_pkg

module eida_ctrl
  import eida_pkg::*;
#(
  parameter int MAX_IDS = MAX_IDS_DEF,
  parameter int ID_W    = $clog2(MAX_IDS),
  parameter int CNT_W   = $clog2(MAX_IDS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_cmd,
  input  logic [ID_W-1:0]  in_eid,
  output logic             sp_we,
  output logic [ID_W-1:0]  sp_addr,
  output logic [CNT_W-1:0] sp_wdata,
  input  logic [CNT_W-1:0] sp_rdata,
  output logic             im_we,
  output logic [ID_W-1:0]  im_addr,
  output logic [ID_W-1:0]  im_wdata,
  input  logic [ID_W-1:0]  im_rdata,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [ID_W-1:0]  res_id,
  output logic [1:0]       res_status,
  output logic [CNT_W-1:0] res_count
);

  localparam logic [CNT_W-1:0] MAX_C   = CNT_W'(MAX_IDS);
  localparam logic [ID_W-1:0]  CLR_END = ID_W'(MAX_IDS - 1);

  state_t           state_r, state_nxt;
  logic [ID_W-1:0]  clr_r, clr_nxt;
  logic [CNT_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0] fresh_r, fresh_nxt;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic             pop_r, pop_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [ID_W-1:0]  eid_r, eid_nxt;
  logic [ID_W-1:0]  rid_r, rid_nxt;
  logic [1:0]       stat_r, stat_nxt;

  logic [CNT_W-1:0] live_m1, pop_pos, push_pos, eid_ext;
  logic [ID_W-1:0]  new_id;

  assign live_m1  = live_r - CNT_W'(1);
  assign pop_pos  = MAX_C - free_r;
  assign push_pos = MAX_C - free_r - CNT_W'(1);
  assign eid_ext  = CNT_W'(in_eid);
  assign new_id   = pop_r ? im_rdata : id_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    free_nxt  = free_r;
    fresh_nxt = fresh_r;
    live_nxt  = live_r;
    pop_nxt   = pop_r;
    id_nxt    = id_r;
    eid_nxt   = eid_r;
    rid_nxt   = rid_r;
    stat_nxt  = stat_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    sp_we     = 1'b0;
    sp_addr   = in_eid;
    sp_wdata  = MAX_C;
    im_we     = 1'b0;
    im_addr   = (in_cmd == CMD_CREATE) ? pop_pos[ID_W-1:0] : live_m1[ID_W-1:0];
    im_wdata  = eid_r;
    case (state_r)
      S_CLEAR: begin
        sp_we   = 1'b1;
        sp_addr = clr_r;
        clr_nxt = clr_r + ID_W'(1);
        if (clr_r == CLR_END) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_CREATE) begin
            if (free_r != '0) begin
              pop_nxt   = 1'b1;
              free_nxt  = free_r - CNT_W'(1);
              state_nxt = S_C_WR;
            end else if (fresh_r < MAX_C) begin
              pop_nxt   = 1'b0;
              id_nxt    = fresh_r[ID_W-1:0];
              fresh_nxt = fresh_r + CNT_W'(1);
              state_nxt = S_C_WR;
            end else begin
              rid_nxt   = '0;
              stat_nxt  = STAT_FULL;
              state_nxt = S_DONE;
            end
          end else begin
            rid_nxt = in_eid;
            eid_nxt = in_eid;
            if (eid_ext >= MAX_C || live_r == '0) begin
              stat_nxt  = STAT_INACTIVE;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_D_CHK;
            end
          end
        end
      end
      S_C_WR: begin
        sp_we     = 1'b1;
        sp_addr   = new_id;
        sp_wdata  = live_r;
        im_we     = 1'b1;
        im_addr   = live_r[ID_W-1:0];
        im_wdata  = new_id;
        live_nxt  = live_r + CNT_W'(1);
        rid_nxt   = new_id;
        stat_nxt  = STAT_OK;
        state_nxt = S_DONE;
      end
      S_D_CHK: begin
        if (sp_rdata >= live_r) begin
          stat_nxt  = STAT_INACTIVE;
          state_nxt = S_DONE;
        end else begin
          // move the last active id into the freed slot
          sp_we     = 1'b1;
          sp_addr   = im_rdata;
          sp_wdata  = sp_rdata;
          im_we     = 1'b1;
          im_addr   = sp_rdata[ID_W-1:0];
          im_wdata  = im_rdata;
          state_nxt = S_D_FIN;
        end
      end
      S_D_FIN: begin
        sp_we    = 1'b1;
        sp_addr  = eid_r;
        sp_wdata = MAX_C;
        live_nxt = live_m1;
        // free stack grows down from the top of the id store
        if (free_r < MAX_C) begin
          im_we    = 1'b1;
          im_addr  = push_pos[ID_W-1:0];
          im_wdata = eid_r;
          free_nxt = free_r + CNT_W'(1);
        end
        stat_nxt  = STAT_OK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      free_r  <= '0;
      fresh_r <= '0;
      live_r  <= '0;
      pop_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      free_r  <= free_nxt;
      fresh_r <= fresh_nxt;
      live_r  <= live_nxt;
      pop_r   <= pop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    eid_r  <= eid_nxt;
    rid_r  <= rid_nxt;
    stat_r <= stat_nxt;
  end

  assign res_id     = rid_r;
  assign res_status = stat_r;
  assign res_count  = live_r;

endmodule

>>> rtl/entity_id_allocator_sparse_set.sv
// top level of the entity id allocator: sequencer, sparse index and id store, output register
// depends on eida_pkg, eida_ctrl, eida_ram

// Entity id allocator built as a sparse set with a free stack. Each word on the input
// stream is one command; each command returns exactly one result word. One command is
// handled at a time, as dependent read then write steps on the two single port memories
// (sparse index and id store, which holds the dense list from the bottom and the free
// stack from the top). A create takes a freed or fresh id, then writes both memories; a
// delete reads both, moves the last active id into the freed slot, then clears the
// index entry and pushes the id; an inactive delete stops after its check, and a create
// when full or a delete with nothing active goes straight to the result. After reset the
// sparse index is swept to invalid, during which in_tready stays low. A new command is
// taken while a result still waits on the output.

module entity_id_allocator_sparse_set
  import eida_pkg::*;
#(
  parameter int MAX_IDS = MAX_IDS_DEF,
  parameter int ID_W    = $clog2(MAX_IDS),
  parameter int CNT_W   = $clog2(MAX_IDS + 1),
  parameter int IN_W    = ((1 + ID_W + 7) / 8) * 8,
  parameter int OUT_W   = ((ID_W + 2 + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // cmd, entity_id
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // result_id, status, active_count
);

  logic             sp_we, im_we;
  logic [ID_W-1:0]  sp_addr, im_addr, im_wdata, im_rdata;
  logic [CNT_W-1:0] sp_wdata, sp_rdata;
  logic             res_valid, res_ready;
  logic [ID_W-1:0]  res_id;
  logic [1:0]       res_status;
  logic [CNT_W-1:0] res_count;

  logic             out_vld_r;
  logic [ID_W-1:0]  out_id_r;
  logic [1:0]       out_stat_r;
  logic [CNT_W-1:0] out_cnt_r;

  eida_ctrl #(
    .MAX_IDS (MAX_IDS),
    .ID_W    (ID_W),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tdata[0]),
    .in_eid     (in_tdata[ID_W:1]),
    .sp_we      (sp_we),
    .sp_addr    (sp_addr),
    .sp_wdata   (sp_wdata),
    .sp_rdata   (sp_rdata),
    .im_we      (im_we),
    .im_addr    (im_addr),
    .im_wdata   (im_wdata),
    .im_rdata   (im_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_id     (res_id),
    .res_status (res_status),
    .res_count  (res_count)
  );

  eida_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_IDS)
  ) u_sparse (
    .clk   (clk),
    .we    (sp_we),
    .addr  (sp_addr),
    .wdata (sp_wdata),
    .rdata (sp_rdata)
  );

  eida_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_IDS)
  ) u_ids (
    .clk   (clk),
    .we    (im_we),
    .addr  (im_addr),
    .wdata (im_wdata),
    .rdata (im_rdata)
  );

  assign res_ready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_ready) begin
      out_vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_id_r   <= res_id;
      out_stat_r <= res_status;
      out_cnt_r  <= res_count;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'({out_cnt_r, out_stat_r, out_id_r});

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_stat_r == STAT_OK || out_stat_r == STAT_FULL ||
                   out_stat_r == STAT_INACTIVE))
    else $error("unknown status code on output");

  a_full_means_all_live: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stat_r == STAT_FULL) |-> (out_cnt_r == CNT_W'(MAX_IDS) && out_id_r == '0))
    else $error("full status while ids remain");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_cnt_r <= CNT_W'(MAX_IDS)))
    else $error("active count above capacity");

endmodule

>>> dv/tb_entity_id_allocator_sparse_set.sv
// testbench for entity_id_allocator_sparse_set: directed table, then random create/delete traffic
// checked word by word against a sparse-set predictor kept in the bench
// depends on eida_pkg and the rtl under rtl/

`timescale 1ns / 1ps

module tb_entity_id_allocator_sparse_set
  import eida_pkg::*;
();

  localparam int NUM_IDS     = MAX_IDS_DEF;
  localparam int IN_W        = 16;
  localparam int OUT_W       = 24;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 150;
  localparam int NUM_ROWS    = 22;

  typedef struct packed {
    logic [9:0]  id;
    logic [1:0]  status;
    logic [10:0] count;
  } result_t;

  typedef struct packed {
    logic        cmd;
    logic [9:0]  eid;
    logic        typed;
    result_t     want;
  } row_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // cmd, entity_id
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // result_id, status, active_count

  entity_id_allocator_sparse_set dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predictor state
  logic [9:0]  dense_ids [NUM_IDS];
  logic [10:0] slot_of   [NUM_IDS];
  logic [9:0]  freed_ids [NUM_IDS];
  int          freed_n;
  int          fresh_id;
  int          live_n;

  result_t     pending_results [$];
  row_t        dir_rows [NUM_ROWS];
  int          mismatches;
  int          quiet_cycles;
  bit          idle_on;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic result_t allocate_or_free(logic c, logic [9:0] eid);
    result_t     r;
    logic [9:0]  id;
    logic [9:0]  moved;
    logic [10:0] slot;
    r = '0;
    if (c == CMD_CREATE) begin
      if (freed_n > 0) begin
        freed_n--;
        id = freed_ids[freed_n];
      end else if (fresh_id < NUM_IDS) begin
        id = 10'(fresh_id);
        fresh_id++;
      end else begin
        r.status = STAT_FULL;
        r.count  = 11'(live_n);
        return r;
      end
      dense_ids[live_n] = id;
      slot_of[id]       = 11'(live_n);
      live_n++;
      r.id     = id;
      r.status = STAT_OK;
    end else begin
      r.id = eid;
      slot = slot_of[eid];
      if (live_n == 0 || slot >= live_n) begin
        r.status = STAT_INACTIVE;
      end else begin
        moved            = dense_ids[live_n-1];
        dense_ids[slot]  = moved;
        slot_of[moved]   = slot;
        live_n--;
        slot_of[eid]     = 11'(NUM_IDS);
        freed_ids[freed_n] = eid;
        freed_n++;
        r.status = STAT_OK;
      end
    end
    r.count = 11'(live_n);
    return r;
  endfunction

  task automatic report_mismatch(string field, int want, int got);
    $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $realtime);
    mismatches++;
  endtask

  task automatic check_result(logic [OUT_W-1:0] word);
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected word", 0, int'(word[22:0]));
      return;
    end
    want = pending_results.pop_front();
    if (word[9:0] != want.id)
      report_mismatch("result_id", int'(want.id), int'(word[9:0]));
    if (word[11:10] != want.status)
      report_mismatch("status", int'(want.status), int'(word[11:10]));
    if (word[22:12] != want.count)
      report_mismatch("active_count", int'(want.count), int'(word[22:12]));
  endtask

  // called right after a falling edge, returns right after a falling edge
  task automatic send_word(logic c, logic [9:0] id, bit typed = 1'b0, result_t want = '0);
    result_t r;
    while (idle_on && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, id, c};
    do @(posedge clk); while (!in_tready);
    r = allocate_or_free(c, id);
    pending_results.insert(pending_results.size(), typed ? want : r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic run_mixed(int n, int create_pct);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < create_pct)
        send_word(CMD_CREATE, 10'($urandom_range(0, NUM_IDS-1)));
      else if (live_n > 0 && pick < 6)
        send_word(CMD_DELETE, dense_ids[$urandom_range(0, live_n-1)]);
      else if (live_n > 0 && pick < 8)
        send_word(CMD_DELETE, dense_ids[live_n-1]);
      else
        send_word(CMD_DELETE, 10'($urandom_range(0, NUM_IDS-1)));
    end
  endtask

  // receiver side
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready <= idle_on ? ($urandom_range(0, 99) >= 25) : 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        check_result(out_tdata);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    freed_n      = 0;
    fresh_id     = 0;
    live_n       = 0;
    foreach (slot_of[i]) slot_of[i] = 11'(NUM_IDS);

    // cmd, entity_id, typed, {result_id, status, active_count}
    dir_rows = '{
      '{CMD_DELETE, 10'd5,    1'b1, '{10'd5,    STAT_INACTIVE, 11'd0}},
      '{CMD_DELETE, 10'd0,    1'b1, '{10'd0,    STAT_INACTIVE, 11'd0}},
      '{CMD_DELETE, 10'd1023, 1'b1, '{10'd1023, STAT_INACTIVE, 11'd0}},
      '{CMD_CREATE, 10'd1023, 1'b1, '{10'd0,    STAT_OK,       11'd1}},
      '{CMD_CREATE, 10'd0,    1'b1, '{10'd1,    STAT_OK,       11'd2}},
      '{CMD_CREATE, 10'd0,    1'b1, '{10'd2,    STAT_OK,       11'd3}},
      '{CMD_DELETE, 10'd1,    1'b1, '{10'd1,    STAT_OK,       11'd2}},
      '{CMD_CREATE, 10'd0,    1'b1, '{10'd1,    STAT_OK,       11'd3}},
      '{CMD_DELETE, 10'd1,    1'b1, '{10'd1,    STAT_OK,       11'd2}},
      '{CMD_DELETE, 10'd1,    1'b1, '{10'd1,    STAT_INACTIVE, 11'd2}},
      '{CMD_DELETE, 10'd2,    1'b1, '{10'd2,    STAT_OK,       11'd1}},
      '{CMD_DELETE, 10'd0,    1'b1, '{10'd0,    STAT_OK,       11'd0}},
      '{CMD_DELETE, 10'd0,    1'b1, '{10'd0,    STAT_INACTIVE, 11'd0}},
      '{CMD_CREATE, 10'd0,    1'b0, '0},
      '{CMD_CREATE, 10'd0,    1'b0, '0},
      '{CMD_CREATE, 10'd0,    1'b0, '0},
      '{CMD_CREATE, 10'd0,    1'b0, '0},
      '{CMD_DELETE, 10'd3,    1'b0, '0},
      '{CMD_DELETE, 10'h2aa,  1'b0, '0},
      '{CMD_DELETE, 10'h155,  1'b0, '0},
      '{CMD_CREATE, 10'h2aa,  1'b0, '0},
      '{CMD_DELETE, 10'd0,    1'b0, '0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].cmd, dir_rows[i].eid, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    // receiver holds off while words keep coming, input must back up
    hold_req = 1'b1;
    run_mixed(150, 55);
    wait_drained();

    // no idling on either side
    idle_on = 1'b0;
    run_mixed(100, 60);
    idle_on = 1'b1;
    wait_drained();

    // fill every id, then push against the full condition
    while (live_n < NUM_IDS)
      send_word(CMD_CREATE, 10'($urandom_range(0, NUM_IDS-1)));
    repeat (6) send_word(CMD_CREATE, 10'($urandom_range(0, NUM_IDS-1)));
    run_mixed(60, 60);
    run_mixed(40, 30);

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> entity_id_allocator_sparse_set.f
rtl/eida_pkg.sv
rtl/eida_ram.sv
rtl/eida_ctrl.sv
rtl/entity_id_allocator_sparse_set.sv
dv/tb_entity_id_allocator_sparse_set.sv
